### hdl/lr_pkg.sv
package lr_pkg;

   // widest coordinate the queue entry carries
   localparam int COORD_MAX = 16;

   // register and field widths
   localparam int CLIP_W     = 12;
   localparam int STRIDE_W   = 15;
   localparam int COLOR_W    = 24;
   localparam int OFFSET_W   = 26;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;

   // register reset values
   localparam logic [CLIP_W-1:0]   CLIP_WIDTH_RST  = CLIP_W'(1020);
   localparam logic [CLIP_W-1:0]   CLIP_HEIGHT_RST = CLIP_W'(969);
   localparam logic [STRIDE_W-1:0] STRIDE_RST      = STRIDE_W'(4096);
   localparam logic [COLOR_W-1:0]  COLOR_RST       = COLOR_W'(24'hFFFFFF);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_CLIP_WIDTH  = 2'd0,
      REG_CLIP_HEIGHT = 2'd1,
      REG_STRIDE      = 2'd2,
      REG_COLOR       = 2'd3
   } reg_type;

   // classified transaction as it waits in the queue
   typedef struct packed {
      op_type                       op;
      logic                         y_major;
      logic                         minor_neg;
      logic signed [COORD_MAX-1:0]  start_x;
      logic signed [COORD_MAX-1:0]  start_y;
      logic signed [COORD_MAX-1:0]  major_end;
      logic [COORD_MAX:0]           delta_major;
      logic [COORD_MAX:0]           delta_minor_abs;
   } entry_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [CLIP_W-1:0]   clip_width;
      logic [CLIP_W-1:0]   clip_height;
      logic [STRIDE_W-1:0] stride;
      logic [COLOR_W-1:0]  color;
   } csr_type;

endpackage

### hdl/lr_front.sv
module lr_front
   import lr_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                         operation,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output entry_type                    entry
);

   localparam int DW = COORD_BITS + 1;

   logic signed [DW-1:0] ax;
   logic signed [DW-1:0] ay;
   logic signed [DW-1:0] bx;
   logic signed [DW-1:0] by;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [DW-1:0] adx;
   logic signed [DW-1:0] ady;
   logic signed [DW-1:0] dmin_raw;
   logic                 y_major;
   logic                 swap;

   // deltas, major axis choice and endpoint ordering
   always_comb begin
      ax = DW'(start_x);
      ay = DW'(start_y);
      bx = DW'(end_x);
      by = DW'(end_y);
      dx = bx - ax;
      dy = by - ay;
      adx = dx[DW-1] ? -dx : dx;
      ady = dy[DW-1] ? -dy : dy;
      y_major = !(ady < adx);
      swap = y_major ? (ay > by) : (ax > bx);
      dmin_raw = y_major ? dx : dy;

      entry.op = op_type'(operation);
      entry.y_major = y_major;
      entry.minor_neg = swap ? (!dmin_raw[DW-1] && (dmin_raw != '0)) : dmin_raw[DW-1];
      entry.start_x = COORD_MAX'(swap ? end_x : start_x);
      entry.start_y = COORD_MAX'(swap ? end_y : start_y);
      entry.major_end = y_major ? COORD_MAX'(swap ? start_y : end_y)
                                : COORD_MAX'(swap ? start_x : end_x);
      entry.delta_major = (COORD_MAX + 1)'(y_major ? ady : adx);
      entry.delta_minor_abs = (COORD_MAX + 1)'(y_major ? adx : ady);
   end

endmodule

### hdl/lr_queue.sv
module lr_queue
   import lr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_entry,
   input  logic      pop,
   output entry_type rd_entry,
   output logic      full,
   output logic      not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_entry  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   // no pop from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   // fill count stays within depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      push && full |=> (count_ff <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue overflow");

endmodule

### hdl/lr_back.sv
module lr_back
   import lr_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  entry_type                    entry,
   input  logic                         q_not_empty,
   output logic                         pop,
   input  csr_type                      csr,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_visible,
   output logic [OFFSET_W-1:0]          rsp_byte_offset,
   output logic [COLOR_W-1:0]           rsp_color,
   output logic                         rsp_last_pixel
);

   localparam int C     = COORD_BITS;
   localparam int EW    = COORD_BITS + 4;
   localparam int CMP_W = ((COORD_BITS > CLIP_W) ? COORD_BITS : CLIP_W) + 1;
   localparam int MUL_W = COORD_BITS + STRIDE_W;
   localparam int SUM_W = ((MUL_W + 1) > OFFSET_W) ? (MUL_W + 1) : OFFSET_W;

   // stepping state
   logic                 busy_ff, busy_in;
   logic                 y_major_ff, y_major_in;
   logic                 minor_neg_ff, minor_neg_in;
   logic signed [C-1:0]  cur_x_ff, cur_x_in;
   logic signed [C-1:0]  cur_y_ff, cur_y_in;
   logic signed [C-1:0]  major_end_ff, major_end_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic signed [EW-1:0] err_up_ff, err_up_in;
   logic signed [EW-1:0] err_dn_ff, err_dn_in;

   // pixel stage
   logic                 a_valid_ff, a_valid_in;
   logic signed [C-1:0]  a_x_ff, a_x_in;
   logic signed [C-1:0]  a_y_ff, a_y_in;
   logic                 a_vis_ff, a_vis_in;
   logic                 a_last_ff, a_last_in;

   // output stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0]  rsp_x_ff, rsp_x_in;
   logic signed [C-1:0]  rsp_y_ff, rsp_y_in;
   logic                 rsp_vis_ff, rsp_vis_in;
   logic [OFFSET_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 advance;
   logic                 a_free;
   logic                 tick_fire;
   logic                 load_fire;
   logic signed [C-1:0]  cur_major;
   logic signed [C:0]    major_next;
   logic                 is_last;
   logic                 err_pos;
   logic                 vis;
   logic signed [EW-1:0] dmaj2;
   logic signed [EW-1:0] dmin2;
   logic signed [EW-1:0] dmin_ext;
   logic signed [EW-1:0] dmaj_ext;
   logic [MUL_W-1:0]     prod_y;
   logic [MUL_W-1:0]     prod_x;
   logic [SUM_W-1:0]     off_sum;

   // pipeline flow
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign a_free    = !a_valid_ff || advance;
   assign pop       = q_not_empty && a_free;
   assign tick_fire = pop && (entry.op == OP_TICK) && busy_ff;
   assign load_fire = pop && (entry.op == OP_LOAD);

   // current pixel, end test and visibility
   always_comb begin
      cur_major  = y_major_ff ? cur_y_ff : cur_x_ff;
      major_next = (C + 1)'(cur_major) + (C + 1)'(1);
      is_last    = (major_next == (C + 1)'(major_end_ff));
      err_pos    = !err_ff[EW-1] && (err_ff != '0);
      vis = !cur_x_ff[C-1] && !cur_y_ff[C-1]
         && (CMP_W'($unsigned(cur_x_ff)) < CMP_W'(csr.clip_width))
         && (CMP_W'($unsigned(cur_y_ff)) < CMP_W'(csr.clip_height));
   end

   // error term setup from the load
   always_comb begin
      dmaj_ext = EW'(entry.delta_major[C:0]);
      dmin_ext = EW'(entry.delta_minor_abs[C:0]);
      dmaj2    = {dmaj_ext[EW-2:0], 1'b0};
      dmin2    = {dmin_ext[EW-2:0], 1'b0};
   end

   // stepping state update
   always_comb begin
      busy_in      = busy_ff;
      y_major_in   = y_major_ff;
      minor_neg_in = minor_neg_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      major_end_in = major_end_ff;
      err_in       = err_ff;
      err_up_in    = err_up_ff;
      err_dn_in    = err_dn_ff;
      if (load_fire) begin
         busy_in      = (entry.delta_major != '0);
         y_major_in   = entry.y_major;
         minor_neg_in = entry.minor_neg;
         cur_x_in     = entry.start_x[C-1:0];
         cur_y_in     = entry.start_y[C-1:0];
         major_end_in = entry.major_end[C-1:0];
         err_in       = dmin2 - dmaj_ext;
         err_up_in    = dmin2 - dmaj2;
         err_dn_in    = dmin2;
      end else if (tick_fire) begin
         err_in = err_ff + (err_pos ? err_up_ff : err_dn_ff);
         if (y_major_ff) begin
            cur_y_in = cur_y_ff + 1'b1;
            if (err_pos) begin
               cur_x_in = minor_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
         end else begin
            cur_x_in = cur_x_ff + 1'b1;
            if (err_pos) begin
               cur_y_in = minor_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
         busy_in = !is_last;
      end
   end

   // pixel stage load
   always_comb begin
      a_valid_in = a_valid_ff;
      a_x_in     = a_x_ff;
      a_y_in     = a_y_ff;
      a_vis_in   = a_vis_ff;
      a_last_in  = a_last_ff;
      if (a_free) begin
         a_valid_in = tick_fire;
         a_x_in     = cur_x_ff;
         a_y_in     = cur_y_ff;
         a_vis_in   = vis;
         a_last_in  = is_last;
      end
   end

   // framebuffer offset and output stage load
   always_comb begin
      prod_y  = MUL_W'($unsigned(a_y_ff)) * MUL_W'(csr.stride);
      prod_x  = MUL_W'($unsigned(a_x_ff)) * MUL_W'(BYTES_PER_PIXEL);
      off_sum = SUM_W'(prod_y) + SUM_W'(prod_x);

      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = a_valid_ff;
         rsp_x_in     = a_x_ff;
         rsp_y_in     = a_y_ff;
         rsp_vis_in   = a_vis_ff;
         rsp_off_in   = a_vis_ff ? off_sum[OFFSET_W-1:0] : '0;
         rsp_color_in = csr.color;
         rsp_last_in  = a_last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      y_major_ff   <= y_major_in;
      minor_neg_ff <= minor_neg_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      major_end_ff <= major_end_in;
      err_ff       <= err_in;
      err_up_ff    <= err_up_in;
      err_dn_ff    <= err_dn_in;
      a_x_ff       <= a_x_in;
      a_y_ff       <= a_y_in;
      a_vis_ff     <= a_vis_in;
      a_last_ff    <= a_last_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_vis_ff   <= rsp_vis_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_visible     = rsp_vis_ff;
   assign rsp_byte_offset = rsp_off_ff;
   assign rsp_color       = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // a tick on an active segment always yields a pixel
   a_tick_emits: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> a_valid_ff)
      else $error("tick on active segment lost its pixel");

   // a zero-length load leaves the stepper idle
   a_zero_len_idle: assert property (@(posedge clock) disable iff (reset)
      load_fire && (entry.delta_major == '0) |=> !busy_ff)
      else $error("zero-length segment left stepper busy");

   // a pixel that moves forward reaches the output register
   a_pixel_reaches_out: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && advance |=> rsp_valid_ff)
      else $error("pixel dropped between stages");

endmodule

### hdl/line_rasterizer_top.sv
// line rasterizer: load and tick transactions in, one pixel transaction out per active tick
// a tick transaction passes the queue, the pixel stage and the output stage before rsp_valid shows its pixel
// throughput: 1 transaction per cycle while rsp_stall is low, set by the single add on the error term per step
// a 4-entry queue separates the classifying front end from the stepping back end
// reset (synchronous, active high) empties the queue and pipeline, idles the stepper
// and returns the configuration registers to their defaults
module line_rasterizer_top
   import lr_pkg::*;
#(
   parameter int COORD_BITS      = 12,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_visible,
   output logic [OFFSET_W-1:0]          rsp_byte_offset,
   output logic [COLOR_W-1:0]           rsp_color,
   output logic                         rsp_last_pixel,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   csr_type   csr_ff;
   csr_type   csr_in;
   reg_type   reg_sel;
   logic      csr_write;
   entry_type front_entry;
   entry_type queue_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      q_push;
   logic      q_pop;

   // configuration register writes
   assign reg_sel   = reg_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_CLIP_WIDTH:  csr_in.clip_width  = pwdata[CLIP_W-1:0];
            REG_CLIP_HEIGHT: csr_in.clip_height = pwdata[CLIP_W-1:0];
            REG_STRIDE:      csr_in.stride      = pwdata[STRIDE_W-1:0];
            REG_COLOR:       csr_in.color       = pwdata[COLOR_W-1:0];
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.clip_width  <= CLIP_WIDTH_RST;
         csr_ff.clip_height <= CLIP_HEIGHT_RST;
         csr_ff.stride      <= STRIDE_RST;
         csr_ff.color       <= COLOR_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // configuration register reads
   always_comb begin
      case (reg_sel)
         REG_CLIP_WIDTH:  prdata = CSR_DATA_W'(csr_ff.clip_width);
         REG_CLIP_HEIGHT: prdata = CSR_DATA_W'(csr_ff.clip_height);
         REG_STRIDE:      prdata = CSR_DATA_W'(csr_ff.stride);
         REG_COLOR:       prdata = CSR_DATA_W'(csr_ff.color);
         default:         prdata = '0;
      endcase
   end

   // front end: classify and enqueue
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   lr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .operation (req_operation),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .entry     (front_entry)
   );

   lr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_entry  (front_entry),
      .pop       (q_pop),
      .rd_entry  (queue_entry),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   // back end: step the segment and emit pixels
   lr_back #(
      .COORD_BITS      (COORD_BITS),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .entry           (queue_entry),
      .q_not_empty     (q_not_empty),
      .pop             (q_pop),
      .csr             (csr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_visible     (rsp_visible),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_color       (rsp_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
